>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the address translator RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge out of reset
`define PTAT_ASSERT_HOLDS(lbl, ck, rn, expr, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (expr)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define PTAT_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define PTAT_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ptat_pkg.sv
// ---------------------------------------------------------------------------
// ptat_pkg
// Codes and fixed widths shared by the address translator modules.
// ---------------------------------------------------------------------------
`default_nettype none

package ptat_pkg;

    localparam int OP_W      = 2;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 2;

    // operations
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
    localparam logic [OP_W-1:0] OP_XLATE = 2'd2;

    // result status
    localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_XLATED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MISSING = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOGICAL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHYSICAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE     = 2'd2;

    // configuration reset values
    localparam logic [63:0] LOGICAL_RESET  = 64'd65536;
    localparam logic [63:0] PHYSICAL_RESET = 64'd65536;
    localparam logic [63:0] PAGE_RESET     = 64'd4096;

endpackage

`default_nettype wire

>>> rtl/ptat_divider.sv
// ---------------------------------------------------------------------------
// ptat_divider
// Restoring divider, one quotient bit per cycle, W steps after start.
// ---------------------------------------------------------------------------
`default_nettype none

module ptat_divider #(
    parameter int W = 41
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic              busy,
    output logic              done,
    output logic [W-1:0]      quotient,
    output logic [W-1:0]      remainder
);

    localparam int CW = $clog2(W + 1);
    localparam logic [CW-1:0] STEPS = CW'(W);
    localparam logic [CW-1:0] LAST  = CW'(1);

    logic [W-1:0]  quot_reg, quot_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  dsr_reg, dsr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;

    assign trial = {rem_reg, quot_reg[W-1]};

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quot_next = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = STEPS;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next  = W'(trial - {1'b0, dsr_reg});
                quot_next = {quot_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[W-1:0];
                quot_next = {quot_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - LAST;
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

>>> rtl/ptat_mul.sv
// ---------------------------------------------------------------------------
// ptat_mul
// Shift-add multiply-accumulate modulo 2^W, stops once the multiplier empties.
// ---------------------------------------------------------------------------
`default_nettype none

module ptat_mul #(
    parameter int W = 40
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] mcand,
    input  wire logic [W-1:0] mplier,
    input  wire logic [W-1:0] addend,
    output logic              done,
    output logic [W-1:0]      result
);

    logic [W-1:0] acc_reg, acc_next;
    logic [W-1:0] mcand_reg, mcand_next;
    logic [W-1:0] mplier_reg, mplier_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;

    always_comb
    begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (start)
        begin
            acc_next    = addend;
            mcand_next  = mcand;
            mplier_next = mplier;
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            if (mplier_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                if (mplier_reg[0])
                begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next  = {mcand_reg[W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[W-1:1]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

`default_nettype wire

>>> rtl/ptat_table.sv
// ---------------------------------------------------------------------------
// ptat_table
// Page/frame entry memory: one write port, one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module ptat_table #(
    parameter int DEPTH  = 64,
    parameter int IDX_W  = 6,
    parameter int DATA_W = 80
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [IDX_W-1:0]  wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [IDX_W-1:0]  rd_addr,
    output logic [DATA_W-1:0]      rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/page_table_address_translator_top.sv
// ---------------------------------------------------------------------------
// page_table_address_translator_top
// Paged logical-to-physical address translation with a small page table.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------------
//   in       | in_valid / in_ready  | operation, page_index, frame_index,
//            |                      | logical_addr
//   out      | out_valid/out_ready  | status, physical_addr, page_offset,
//            |                      | looked_up_page
//   cfg      | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// Clear goes straight to the response. Add: two passes of the serial
// divider, then a range and room check. Translate: one divider pass, a
// search of the stored entries through the table read port, then a
// shift-add multiply over the significant bits of the page size.
// Reset restores the default sizes and empties the table at once.
// The result sits in an output register; the next item is taken while it
// waits, and the sequencer holds its result until the register frees up.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module page_table_address_translator_top #(
    parameter int TABLE_ENTRIES = 64,
    parameter int ADDR_BITS     = 40
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [ptat_pkg::OP_W-1:0]     operation,
    input  wire logic [ADDR_BITS-1:0]          page_index,
    input  wire logic [ADDR_BITS-1:0]          frame_index,
    input  wire logic [ADDR_BITS-1:0]          logical_addr,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [ptat_pkg::STATUS_W-1:0]      status,
    output logic [ADDR_BITS-1:0]               physical_addr,
    output logic [ADDR_BITS-1:0]               page_offset,
    output logic [ADDR_BITS-1:0]               looked_up_page,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [ptat_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ADDR_BITS:0]            cfg_data
);

    localparam int A      = ADDR_BITS;
    localparam int SIZE_W = ADDR_BITS + 1;
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);
    localparam logic [CNT_W-1:0] CNT_ONE    = CNT_W'(1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_LOG,
        S_WAIT_LOG,
        S_DIV_PHYS,
        S_WAIT_PHYS,
        S_CHECK,
        S_DIV_ADDR,
        S_WAIT_ADDR,
        S_SEARCH,
        S_WAIT_MUL,
        S_RESP
    } state_t;

    state_t state_reg, state_next;

    logic [SIZE_W-1:0] logical_reg, logical_next;
    logic [SIZE_W-1:0] physical_reg, physical_next;
    logic [SIZE_W-1:0] page_size_reg, page_size_next;
    logic [SIZE_W-1:0] npages_reg, npages_next;
    logic [SIZE_W-1:0] nframes_reg, nframes_next;
    logic [A-1:0]      pg_reg, pg_next;
    logic [A-1:0]      fr_reg, fr_next;
    logic [A-1:0]      la_reg, la_next;
    logic [A-1:0]      lpage_reg, lpage_next;
    logic [A-1:0]      offs_reg, offs_next;
    logic [A-1:0]      phys_reg, phys_next;
    logic [ptat_pkg::STATUS_W-1:0] st_reg, st_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  issue_idx_reg, issue_idx_next;
    logic              pend_reg, pend_next;

    logic              out_valid_reg, out_valid_next;
    logic [ptat_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [A-1:0]      physical_addr_reg, physical_addr_next;
    logic [A-1:0]      page_offset_reg, page_offset_next;
    logic [A-1:0]      looked_up_page_reg, looked_up_page_next;

    logic [SIZE_W-1:0] psz;
    logic              in_fire;

    logic              div_start, div_busy, div_done;
    logic [SIZE_W-1:0] div_dividend, div_quot, div_rem;

    logic              mul_start, mul_done;
    logic [A-1:0]      mul_result;

    logic              tbl_wr_en, tbl_rd_en;
    logic [2*A-1:0]    tbl_rd_data;
    logic [A-1:0]      rd_page, rd_frame;
    logic              hit;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && in_ready;
    assign psz       = (page_size_reg == '0) ? SIZE_W'(1) : page_size_reg;

    assign rd_page  = tbl_rd_data[2*A-1:A];
    assign rd_frame = tbl_rd_data[A-1:0];
    assign hit      = (state_reg == S_SEARCH) && pend_reg && (rd_page == lpage_reg);

    assign div_start = (state_reg == S_DIV_LOG) || (state_reg == S_DIV_PHYS) ||
                       (state_reg == S_DIV_ADDR);
    assign mul_start = hit;

    always_comb
    begin
        case (state_reg)
            S_DIV_LOG:  div_dividend = logical_reg;
            S_DIV_PHYS: div_dividend = physical_reg;
            default:    div_dividend = {1'b0, la_reg};
        endcase
    end

    always_comb
    begin
        state_next          = state_reg;
        logical_next        = logical_reg;
        physical_next       = physical_reg;
        page_size_next      = page_size_reg;
        npages_next         = npages_reg;
        nframes_next        = nframes_reg;
        pg_next             = pg_reg;
        fr_next             = fr_reg;
        la_next             = la_reg;
        lpage_next          = lpage_reg;
        offs_next           = offs_reg;
        phys_next           = phys_reg;
        st_next             = st_reg;
        count_next          = count_reg;
        issue_idx_next      = issue_idx_reg;
        pend_next           = pend_reg;
        out_valid_next      = out_valid_reg && !out_ready;
        status_next         = status_reg;
        physical_addr_next  = physical_addr_reg;
        page_offset_next    = page_offset_reg;
        looked_up_page_next = looked_up_page_reg;
        tbl_wr_en           = 1'b0;
        tbl_rd_en           = 1'b0;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                ptat_pkg::CFG_LOGICAL:  logical_next   = cfg_data;
                ptat_pkg::CFG_PHYSICAL: physical_next  = cfg_data;
                ptat_pkg::CFG_PAGE:     page_size_next = cfg_data;
                default:                ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    pg_next    = page_index;
                    fr_next    = frame_index;
                    la_next    = logical_addr;
                    lpage_next = '0;
                    offs_next  = '0;
                    phys_next  = '0;
                    case (operation)
                        ptat_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                            st_next    = ptat_pkg::ST_CLEARED;
                            state_next = S_RESP;
                        end
                        ptat_pkg::OP_ADD:   state_next = S_DIV_LOG;
                        ptat_pkg::OP_XLATE: state_next = S_DIV_ADDR;
                        default:            state_next = S_IDLE;
                    endcase
                end
            end
            S_DIV_LOG:  state_next = S_WAIT_LOG;
            S_WAIT_LOG:
            begin
                if (div_done)
                begin
                    npages_next = div_quot;
                    state_next  = S_DIV_PHYS;
                end
            end
            S_DIV_PHYS: state_next = S_WAIT_PHYS;
            S_WAIT_PHYS:
            begin
                if (div_done)
                begin
                    nframes_next = div_quot;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (({1'b0, pg_reg} >= npages_reg) || ({1'b0, fr_reg} >= nframes_reg))
                begin
                    st_next = ptat_pkg::ST_RANGE;
                end
                else if (count_reg == FULL_COUNT)
                begin
                    st_next = ptat_pkg::ST_FULL;
                end
                else
                begin
                    tbl_wr_en  = 1'b1;
                    count_next = count_reg + CNT_ONE;
                    st_next    = ptat_pkg::ST_ADDED;
                end
                state_next = S_RESP;
            end
            S_DIV_ADDR: state_next = S_WAIT_ADDR;
            S_WAIT_ADDR:
            begin
                if (div_done)
                begin
                    lpage_next     = div_quot[A-1:0];
                    offs_next      = div_rem[A-1:0];
                    issue_idx_next = '0;
                    pend_next      = 1'b0;
                    state_next     = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (hit)
                begin
                    pend_next  = 1'b0;
                    state_next = S_WAIT_MUL;
                end
                else if (issue_idx_reg == count_reg)
                begin
                    pend_next  = 1'b0;
                    st_next    = ptat_pkg::ST_MISSING;
                    state_next = S_RESP;
                end
                else
                begin
                    tbl_rd_en      = 1'b1;
                    issue_idx_next = issue_idx_reg + CNT_ONE;
                    pend_next      = 1'b1;
                end
            end
            S_WAIT_MUL:
            begin
                if (mul_done)
                begin
                    phys_next  = mul_result;
                    st_next    = ptat_pkg::ST_XLATED;
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next      = 1'b1;
                    status_next         = st_reg;
                    physical_addr_next  = phys_reg;
                    page_offset_next    = offs_reg;
                    looked_up_page_next = lpage_reg;
                    state_next          = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            logical_reg        <= SIZE_W'(ptat_pkg::LOGICAL_RESET);
            physical_reg       <= SIZE_W'(ptat_pkg::PHYSICAL_RESET);
            page_size_reg      <= SIZE_W'(ptat_pkg::PAGE_RESET);
            npages_reg         <= '0;
            nframes_reg        <= '0;
            pg_reg             <= '0;
            fr_reg             <= '0;
            la_reg             <= '0;
            lpage_reg          <= '0;
            offs_reg           <= '0;
            phys_reg           <= '0;
            st_reg             <= ptat_pkg::ST_CLEARED;
            count_reg          <= '0;
            issue_idx_reg      <= '0;
            pend_reg           <= 1'b0;
            out_valid_reg      <= 1'b0;
            status_reg         <= ptat_pkg::ST_CLEARED;
            physical_addr_reg  <= '0;
            page_offset_reg    <= '0;
            looked_up_page_reg <= '0;
        end
        else
        begin
            state_reg          <= state_next;
            logical_reg        <= logical_next;
            physical_reg       <= physical_next;
            page_size_reg      <= page_size_next;
            npages_reg         <= npages_next;
            nframes_reg        <= nframes_next;
            pg_reg             <= pg_next;
            fr_reg             <= fr_next;
            la_reg             <= la_next;
            lpage_reg          <= lpage_next;
            offs_reg           <= offs_next;
            phys_reg           <= phys_next;
            st_reg             <= st_next;
            count_reg          <= count_next;
            issue_idx_reg      <= issue_idx_next;
            pend_reg           <= pend_next;
            out_valid_reg      <= out_valid_next;
            status_reg         <= status_next;
            physical_addr_reg  <= physical_addr_next;
            page_offset_reg    <= page_offset_next;
            looked_up_page_reg <= looked_up_page_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign physical_addr  = physical_addr_reg;
    assign page_offset    = page_offset_reg;
    assign looked_up_page = looked_up_page_reg;

    ptat_divider #(
        .W(SIZE_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (psz),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot),
        .remainder(div_rem)
    );

    ptat_mul #(
        .W(A)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .mcand (rd_frame),
        .mplier(psz[A-1:0]),
        .addend(offs_reg),
        .done  (mul_done),
        .result(mul_result)
    );

    ptat_table #(
        .DEPTH (TABLE_ENTRIES),
        .IDX_W (IDX_W),
        .DATA_W(2 * A)
    ) u_table (
        .clk    (clk),
        .wr_en  (tbl_wr_en),
        .wr_addr(count_reg[IDX_W-1:0]),
        .wr_data({pg_reg, fr_reg}),
        .rd_en  (tbl_rd_en),
        .rd_addr(issue_idx_reg[IDX_W-1:0]),
        .rd_data(tbl_rd_data)
    );

    `PTAT_ASSERT_HOLDS(a_count_bound, clk, rst_n, count_reg <= FULL_COUNT, "entry count overflow")
    `PTAT_ASSERT_IMPL(a_write_room, clk, rst_n, tbl_wr_en, count_reg < FULL_COUNT, "write to full table")
    `PTAT_ASSERT_IMPL(a_div_idle, clk, rst_n, div_start, !div_busy, "divider restarted while busy")
    `PTAT_ASSERT_NEXT(a_clear_empties, clk, rst_n, in_fire && (operation == ptat_pkg::OP_CLEAR), count_reg == '0, "clear left entries")
    `PTAT_ASSERT_IMPL(a_phys_zero, clk, rst_n, out_valid_reg && (status_reg != ptat_pkg::ST_XLATED), physical_addr_reg == '0, "address on non-translate item")

endmodule

`default_nettype wire
